// ----- rtl/ebcf_pkg.sv -----
// shared types and constants of the error blink-code flasher
package ebcf_pkg;

  localparam int unsigned CountWidth = 8;
  localparam int unsigned SevWidth   = 3;
  localparam int unsigned CodeWidth  = 7;
  localparam int unsigned CfgIdxWidth = 8;

  localparam logic [CfgIdxWidth-1:0] RegTickDivideRatio = 8'd0;
  localparam logic [CfgIdxWidth-1:0] RegGapSteps        = 8'd1;

  localparam logic [CountWidth-1:0] TickDivideRatioReset = 8'd10;
  localparam logic [CountWidth-1:0] GapStepsReset        = 8'd10;

  localparam logic ModeTick  = 1'b0;
  localparam logic ModeEvent = 1'b1;

  typedef struct packed {
    logic                  led_pin;
    logic [CountWidth-1:0] edges_pending;
    logic                  in_gap;
  } result_t;

endpackage

// ----- rtl/error_blink_code_flasher.sv -----
// error blink-code flasher: event arbitration, tick divider and led sequencer
//
// input channel (in_valid/in_ready): mode 0 is a base timer tick, mode 1 is an
// event report carrying severity and blink_code. every input transaction
// produces exactly one result transaction on the output channel
// (out_valid/out_ready) carrying led_pin, edges_pending and in_gap.
// configuration channel (cfg_valid/cfg_ready): cfg_index 0 writes the tick
// divide ratio, 1 writes the gap length in steps; other indexes are dropped.
// cfg_ready is always high.
// the result of an item is registered in the result register, or in the skid
// register while a result waits. throughput: one item per cycle while in_ready
// is high, set by the state update and the result register.
// a skid register behind the result register lets one more item be taken
// while a result waits; with both full, in_ready drops until the receiver
// takes a result.
// reset: led pin high, all counters and the held event cleared, both registers
// back to 10, output channel empty.
module error_blink_code_flasher (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          mode,
  input  logic [ebcf_pkg::SevWidth-1:0]  severity,
  input  logic [ebcf_pkg::CodeWidth-1:0] blink_code,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          led_pin,
  output logic [ebcf_pkg::CountWidth-1:0] edges_pending,
  output logic                          in_gap,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ebcf_pkg::CfgIdxWidth-1:0] cfg_index,
  input  logic [ebcf_pkg::CountWidth-1:0]  cfg_data
);

  logic [ebcf_pkg::CountWidth-1:0] tick_divide_ratio;
  logic [ebcf_pkg::CountWidth-1:0] gap_steps;

  logic [ebcf_pkg::CountWidth-1:0] tick_divider, tick_divider_next;
  logic [ebcf_pkg::CountWidth-1:0] pending_edges, pending_edges_next;
  logic [ebcf_pkg::CountWidth-1:0] gap_counter, gap_counter_next;
  logic [ebcf_pkg::SevWidth-1:0]   held_severity, held_severity_next;
  logic [ebcf_pkg::CodeWidth-1:0]  held_code, held_code_next;
  logic                            pin_level, pin_level_next;

  ebcf_pkg::result_t out_data, skid_data, result_next;
  logic              skid_valid;

  logic in_accept;
  logic out_take;
  logic cfg_accept;
  logic [ebcf_pkg::CountWidth-1:0] div_inc;
  logic step;
  logic event_take;
  logic [ebcf_pkg::CountWidth-1:0] edge_base;

  assign in_ready   = !skid_valid;
  assign in_accept  = in_valid && in_ready;
  assign out_take   = out_valid && out_ready;
  assign cfg_ready  = 1'b1;
  assign cfg_accept = cfg_valid && cfg_ready;

  assign div_inc    = tick_divider + 8'd1;
  assign step       = (mode == ebcf_pkg::ModeTick) && (div_inc == tick_divide_ratio);
  assign event_take = (pending_edges == '0) || (severity > held_severity);
  assign edge_base  = (blink_code != held_code) ? '0 : pending_edges;

  always_comb begin
    tick_divider_next  = tick_divider;
    pending_edges_next = pending_edges;
    gap_counter_next   = gap_counter;
    held_severity_next = held_severity;
    held_code_next     = held_code;
    pin_level_next     = pin_level;
    unique case (mode)
      ebcf_pkg::ModeTick: begin
        tick_divider_next = step ? '0 : div_inc;
        if (step) begin
          if (gap_counter == '0) begin
            if (pending_edges != '0) begin
              pending_edges_next = pending_edges - 8'd1;
              pin_level_next     = !pin_level;
              if (pending_edges == 8'd1) begin
                gap_counter_next = gap_steps;
              end
            end else begin
              pin_level_next = 1'b1;
            end
          end else begin
            gap_counter_next = gap_counter - 8'd1;
          end
        end
      end
      ebcf_pkg::ModeEvent: begin
        if (event_take) begin
          if (blink_code != held_code) begin
            pin_level_next = 1'b1;
          end
          held_severity_next = severity;
          held_code_next     = blink_code;
          pending_edges_next = edge_base + {blink_code, 1'b0};
        end
      end
      default: begin
      end
    endcase
    result_next.led_pin       = pin_level_next;
    result_next.edges_pending = pending_edges_next;
    result_next.in_gap        = (gap_counter_next != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_divide_ratio <= ebcf_pkg::TickDivideRatioReset;
      gap_steps         <= ebcf_pkg::GapStepsReset;
    end else if (cfg_accept) begin
      if (cfg_index == ebcf_pkg::RegTickDivideRatio) begin
        tick_divide_ratio <= cfg_data;
      end else if (cfg_index == ebcf_pkg::RegGapSteps) begin
        gap_steps <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_divider  <= '0;
      pending_edges <= '0;
      gap_counter   <= '0;
      held_severity <= '0;
      held_code     <= '0;
      pin_level     <= 1'b1;
    end else if (in_accept) begin
      tick_divider  <= tick_divider_next;
      pending_edges <= pending_edges_next;
      gap_counter   <= gap_counter_next;
      held_severity <= held_severity_next;
      held_code     <= held_code_next;
      pin_level     <= pin_level_next;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_take || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_accept;
      end
    end else if (in_accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take || !out_valid) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (in_accept) begin
        out_data <= result_next;
      end
    end else if (in_accept) begin
      skid_data <= result_next;
    end
  end

  assign led_pin       = out_data.led_pin;
  assign edges_pending = out_data.edges_pending;
  assign in_gap        = out_data.in_gap;

  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage full with output register empty");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_new_code_restarts: assert property (@(posedge clk) disable iff (rst)
    in_accept && (mode == ebcf_pkg::ModeEvent) && event_take && (blink_code != held_code)
    |=> pending_edges == {$past(blink_code), 1'b0})
    else $error("new event code did not restart edge count");

  a_gap_countdown: assert property (@(posedge clk) disable iff (rst)
    in_accept && step && (gap_counter != '0)
    |=> (gap_counter == $past(gap_counter) - 8'd1) && (pin_level == $past(pin_level)))
    else $error("gap step did not count down");

  a_ignored_event: assert property (@(posedge clk) disable iff (rst)
    in_accept && (mode == ebcf_pkg::ModeEvent) && !event_take
    |=> $stable(pending_edges) && $stable(held_code) && $stable(pin_level))
    else $error("lower severity event changed state");

endmodule

// ----- verif/tb_error_blink_code_flasher.sv -----
`timescale 1ns / 1ps
// testbench for the error blink-code flasher: random ticks, events and register settings

module tb_error_blink_code_flasher;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned PhaseItems = 230;
  localparam int unsigned HoldCycles = 60;

  class blink_scoreboard;
    logic [ebcf_pkg::CountWidth-1:0] ratio;
    logic [ebcf_pkg::CountWidth-1:0] gap_len;
    logic [ebcf_pkg::CountWidth-1:0] divider;
    logic [ebcf_pkg::CountWidth-1:0] edges;
    logic [ebcf_pkg::CountWidth-1:0] gap_cnt;
    logic [ebcf_pkg::SevWidth-1:0]   held_sev;
    logic [ebcf_pkg::CodeWidth-1:0]  held_code;
    logic                            pin;
    ebcf_pkg::result_t               expected_status[$];
    int unsigned                     errors;

    function new();
      ratio     = ebcf_pkg::TickDivideRatioReset;
      gap_len   = ebcf_pkg::GapStepsReset;
      divider   = '0;
      edges     = '0;
      gap_cnt   = '0;
      held_sev  = '0;
      held_code = '0;
      pin       = 1'b1;
      errors    = 0;
    endfunction

    function void write_reg(logic [ebcf_pkg::CfgIdxWidth-1:0] idx,
                            logic [ebcf_pkg::CountWidth-1:0] data);
      case (idx)
        ebcf_pkg::RegTickDivideRatio: ratio = data;
        ebcf_pkg::RegGapSteps:        gap_len = data;
        default: ;
      endcase
    endfunction

    function void flasher_step();
      if (gap_cnt == '0) begin
        if (edges != '0) begin
          edges = edges - 8'd1;
          pin = ~pin;
          if (edges == '0) gap_cnt = gap_len;
        end else begin
          pin = 1'b1;
        end
      end else begin
        gap_cnt = gap_cnt - 8'd1;
      end
    endfunction

    function ebcf_pkg::result_t predict_status(logic m, logic [ebcf_pkg::SevWidth-1:0] sev,
                                               logic [ebcf_pkg::CodeWidth-1:0] code);
      ebcf_pkg::result_t r;
      if (m == ebcf_pkg::ModeTick) begin
        divider = divider + 8'd1;
        if (divider == ratio) begin
          divider = '0;
          flasher_step();
        end
      end else if (edges == '0 || sev > held_sev) begin
        if (code != held_code) begin
          edges = '0;
          pin = 1'b1;
        end
        held_sev  = sev;
        held_code = code;
        edges = edges + {code, 1'b0};
      end
      r.led_pin       = pin;
      r.edges_pending = edges;
      r.in_gap        = (gap_cnt != '0);
      return r;
    endfunction

    function void note_input(logic m, logic [ebcf_pkg::SevWidth-1:0] sev,
                             logic [ebcf_pkg::CodeWidth-1:0] code);
      expected_status.push_back(predict_status(m, sev, code));
    endfunction

    function int unsigned outstanding();
      return expected_status.size();
    endfunction

    task report_mismatch(string what, int unsigned want, int unsigned seen);
      $display("%0t mismatch on %s: expected 0x%0h, seen 0x%0h", $time, what, want, seen);
      errors++;
    endtask

    task check_result(logic led, logic [ebcf_pkg::CountWidth-1:0] pend, logic gap);
      ebcf_pkg::result_t e;
      if (expected_status.size() == 0) begin
        report_mismatch("result with none expected", 0, pend);
      end else begin
        e = expected_status.pop_front();
        if (led !== e.led_pin) report_mismatch("led_pin", e.led_pin, led);
        if (pend !== e.edges_pending) report_mismatch("edges_pending", e.edges_pending, pend);
        if (gap !== e.in_gap) report_mismatch("in_gap", e.in_gap, gap);
      end
    endtask

    task final_check();
      if (expected_status.size() != 0)
        report_mismatch("results never seen", 0, expected_status.size());
    endtask
  endclass

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic                             mode = ebcf_pkg::ModeTick;
  logic [ebcf_pkg::SevWidth-1:0]    severity = '0;
  logic [ebcf_pkg::CodeWidth-1:0]   blink_code = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic                             led_pin;
  logic [ebcf_pkg::CountWidth-1:0]  edges_pending;
  logic                             in_gap;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [ebcf_pkg::CfgIdxWidth-1:0] cfg_index = '0;
  logic [ebcf_pkg::CountWidth-1:0]  cfg_data = '0;

  logic                             calm = 1'b0;
  logic                             hold_rx = 1'b0;
  int unsigned                      stall_count = 0;
  logic [ebcf_pkg::CountWidth-1:0]  ratio_plan [8];
  logic [ebcf_pkg::CountWidth-1:0]  gap_plan [8];

  blink_scoreboard sb = new();

  error_blink_code_flasher i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .mode(mode),
    .severity(severity),
    .blink_code(blink_code),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .led_pin(led_pin),
    .edges_pending(edges_pending),
    .in_gap(in_gap),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  task automatic offer_item(logic m, logic [ebcf_pkg::SevWidth-1:0] sev,
                            logic [ebcf_pkg::CodeWidth-1:0] code);
    in_valid   <= 1'b1;
    mode       <= m;
    severity   <= sev;
    blink_code <= code;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic sender_gap();
    while (!calm && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(logic [ebcf_pkg::CfgIdxWidth-1:0] idx,
                                logic [ebcf_pkg::CountWidth-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // transaction monitor and stall watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) sb.note_input(mode, severity, blink_code);
      if (out_valid && out_ready) sb.check_result(led_pin, edges_pending, in_gap);
      if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
        stall_count = 0;
      else
        stall_count++;
      if (stall_count == StallLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // receiver
  initial begin
    wait (!rst);
    forever begin
      @(posedge clk);
      if (hold_rx) begin
        hold_rx = 1'b0;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 21);
      end
    end
  end

  initial begin
    ratio_plan = '{8'd2, 8'd1, 8'd255, 8'd0, 8'd3, 8'd1, 8'd4, 8'd2};
    gap_plan   = '{8'd5, 8'd0, 8'd3, 8'd1, 8'd10, 8'd2, 8'd255, 8'd0};
    ratio_plan[6] = 8'($urandom_range(254, 1));
    gap_plan[7]   = 8'($urandom);
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // severity arbitration and code changes at reset settings
    offer_item(ebcf_pkg::ModeEvent, 3'd0, 7'd0);
    offer_item(ebcf_pkg::ModeEvent, 3'd1, 7'd3);
    offer_item(ebcf_pkg::ModeEvent, 3'd1, 7'd5);
    offer_item(ebcf_pkg::ModeEvent, 3'd0, 7'd127);
    offer_item(ebcf_pkg::ModeEvent, 3'd7, 7'd127);
    offer_item(ebcf_pkg::ModeEvent, 3'd7, 7'd127);
    repeat (10) offer_item(ebcf_pkg::ModeTick, 3'($urandom), 7'($urandom));

    // zero gap, edge count wrap, clear on new code
    drain_results();
    write_register(ebcf_pkg::RegTickDivideRatio, 8'd1);
    write_register(ebcf_pkg::RegGapSteps, 8'd0);
    offer_item(ebcf_pkg::ModeEvent, 3'd2, 7'd1);
    repeat (4) offer_item(ebcf_pkg::ModeTick, 3'($urandom), 7'($urandom));
    offer_item(ebcf_pkg::ModeEvent, 3'd3, 7'd127);
    offer_item(ebcf_pkg::ModeEvent, 3'd4, 7'd127);
    offer_item(ebcf_pkg::ModeEvent, 3'd5, 7'd0);

    // divider left above the next ratio
    drain_results();
    write_register(ebcf_pkg::RegTickDivideRatio, 8'd200);
    repeat (3) offer_item(ebcf_pkg::ModeTick, 3'($urandom), 7'($urandom));

    for (int p = 0; p < 8; p++) begin
      drain_results();
      write_register(ebcf_pkg::RegTickDivideRatio, ratio_plan[p]);
      write_register(ebcf_pkg::RegGapSteps, gap_plan[p]);
      write_register(8'($urandom_range(255, 2)), 8'($urandom));
      if (p == 1) hold_rx = 1'b1;
      for (int n = 0; n < PhaseItems; n++) begin
        calm = (p == 5 && n < 150) || (p == 1 && n < 20);
        if (p == 2 && n == 100) drain_results();
        sender_gap();
        if ($urandom_range(99) < 25)
          offer_item(ebcf_pkg::ModeEvent, 3'($urandom_range(7)),
                     ($urandom_range(99) < 60) ? 7'($urandom_range(4, 1))
                                               : 7'($urandom_range(127)));
        else
          offer_item(ebcf_pkg::ModeTick, 3'($urandom), 7'($urandom));
      end
    end
    calm = 1'b0;

    drain_results();
    sb.final_check();
    if (sb.errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
